[rtl/sbamd_pkg.sv]
// Shared types and constants of the signed byte ALU with pipelined multiply and divide.
package sbamd_pkg;

  // Operand width in bits; the magnitudes of the operands fit in the same width.
  localparam int unsigned DataWidth = 8;
  // Width of the full product and of the result field.
  localparam int unsigned ProdWidth = 2 * DataWidth;
  // One cell of the chain handles one multiplier bit and one quotient bit.
  localparam int unsigned NumCells = DataWidth;

  // Magnitude of the most negative operand, and the constant one.
  localparam logic [DataWidth-1:0] MinMag = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0] OneMag = {{(DataWidth-1){1'b0}}, 1'b1};

  // Operation codes.
  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActSub = 2'd1,
    ActMul = 2'd2,
    ActDiv = 2'd3
  } act_e;

  // One request.
  typedef struct packed {
    act_e                        action;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
  } req_t;

  // One result.
  typedef struct packed {
    logic signed [ProdWidth-1:0] result_value;
    logic signed [DataWidth-1:0] remainder_value;
    logic                        overflow_flag;
    logic                        divide_by_zero;
  } res_t;

  // Work carried from cell to cell along the chain.
  typedef struct packed {
    act_e                        action;
    logic signed [DataWidth-1:0] operand_a;
    logic signed [DataWidth-1:0] operand_b;
    logic [ProdWidth-1:0]        mul_m;    // multiplicand, shifted left once per cell
    logic [DataWidth-1:0]        mul_q;    // multiplier, shifted right once per cell
    logic [ProdWidth-1:0]        acc;      // partial product
    logic [DataWidth-1:0]        div_n;    // dividend bits still to be brought down
    logic [DataWidth-1:0]        div_d;    // divisor magnitude
    logic [DataWidth-1:0]        rem;      // partial remainder
    logic [DataWidth-1:0]        quo;      // quotient bits so far
  } cell_t;

endpackage

[rtl/sbamd_cell.sv]
// One cell of the chain: one shift-add step and one restoring division step.
module sbamd_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sbamd_pkg::cell_t     data_i,
  output logic                 valid_o,
  output sbamd_pkg::cell_t     data_o
);

  logic                                valid_q;
  sbamd_pkg::cell_t                    data_d;
  sbamd_pkg::cell_t                    data_q;
  logic [sbamd_pkg::DataWidth-1:0]     part_rem;

  // Multiply step on the low multiplier bit, divide step on the top dividend bit.
  always_comb begin
    data_d   = data_i;
    part_rem = {data_i.rem[sbamd_pkg::DataWidth-2:0], data_i.div_n[sbamd_pkg::DataWidth-1]};
    if (data_i.mul_q[0]) begin
      data_d.acc = data_i.acc + data_i.mul_m;
    end
    data_d.mul_m = {data_i.mul_m[sbamd_pkg::ProdWidth-2:0], 1'b0};
    data_d.mul_q = {1'b0, data_i.mul_q[sbamd_pkg::DataWidth-1:1]};
    data_d.div_n = {data_i.div_n[sbamd_pkg::DataWidth-2:0], 1'b0};
    if (part_rem >= data_i.div_d) begin
      data_d.rem = part_rem - data_i.div_d;
      data_d.quo = {data_i.quo[sbamd_pkg::DataWidth-2:0], 1'b1};
    end else begin
      data_d.rem = part_rem;
      data_d.quo = {data_i.quo[sbamd_pkg::DataWidth-2:0], 1'b0};
    end
  end

  // The valid bit is reset; the work itself needs none.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/sbamd_out.sv]
// Output stage: sign fix, add and subtract, flags, and the result register.
module sbamd_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sbamd_pkg::cell_t     data_i,
  output logic                 done_o,
  output sbamd_pkg::res_t      res_o
);

  localparam int unsigned W = sbamd_pkg::DataWidth;
  localparam int unsigned P = sbamd_pkg::ProdWidth;

  logic             done_q;
  sbamd_pkg::res_t  res_d;
  sbamd_pkg::res_t  res_q;
  logic [W:0]       a_ext;
  logic [W:0]       b_ext;
  logic [W:0]       exact;
  logic             sign_a;
  logic             sign_b;
  logic [W-1:0]     quo_s;
  logic [W-1:0]     rem_s;

  // Form the signed result for the operation carried down the chain.
  always_comb begin
    sign_a = data_i.operand_a[W-1];
    sign_b = data_i.operand_b[W-1];
    a_ext  = {sign_a, data_i.operand_a};
    b_ext  = {sign_b, data_i.operand_b};
    exact  = (data_i.action == sbamd_pkg::ActSub) ? (a_ext - b_ext) : (a_ext + b_ext);
    quo_s  = (sign_a ^ sign_b) ? (~data_i.quo + sbamd_pkg::OneMag) : data_i.quo;
    rem_s  = sign_a ? (~data_i.rem + sbamd_pkg::OneMag) : data_i.rem;
    res_d  = '0;
    case (data_i.action) inside
      sbamd_pkg::ActAdd, sbamd_pkg::ActSub: begin
        res_d.result_value  = {{(P-W){exact[W-1]}}, exact[W-1:0]};
        res_d.overflow_flag = exact[W] ^ exact[W-1];
      end
      sbamd_pkg::ActMul: begin
        res_d.result_value = (sign_a ^ sign_b) ? (~data_i.acc + P'(1)) : data_i.acc;
      end
      default: begin
        // A zero divisor leaves every other field at zero.
        if (data_i.operand_b == '0) begin
          res_d.divide_by_zero = 1'b1;
        end else begin
          res_d.result_value    = {{(P-W){quo_s[W-1]}}, quo_s};
          res_d.remainder_value = rem_s;
          res_d.overflow_flag   = !(sign_a ^ sign_b) && (data_i.quo == sbamd_pkg::MinMag);
        end
      end
    endcase
  end

  // Result strobe and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[rtl/signed_byte_alu_mul_div.sv]
// Top level of the signed byte ALU: operand decode, the cell chain and the output stage.
//
//  Channel   Direction  Signals                   Transfer
//  request   in         start, busy, req_i        start high while busy low
//  result    out        done_o, res_o             done_o high for one cycle
//
// A request is taken in every cycle; busy never rises.
// Every result passes through eight cells, one per operand bit, then the
// output register.
// Results leave in request order and the receiver cannot stall them.
// Reset clears the valid bits of the chain and the result strobe only.
module signed_byte_alu_mul_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  sbamd_pkg::req_t      req_i,
  output logic                 done_o,
  output sbamd_pkg::res_t      res_o
);

  localparam int unsigned W = sbamd_pkg::DataWidth;
  localparam int unsigned N = sbamd_pkg::NumCells;

  logic                      accept;
  logic [W-1:0]              mag_a;
  logic [W-1:0]              mag_b;
  sbamd_pkg::cell_t          head;
  logic [N:0]                chain_valid;
  sbamd_pkg::cell_t [N:0]    chain_data;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Operand magnitudes and the initial work for the first cell.
  always_comb begin
    mag_a = req_i.operand_a[W-1] ? (~req_i.operand_a + sbamd_pkg::OneMag) : req_i.operand_a;
    mag_b = req_i.operand_b[W-1] ? (~req_i.operand_b + sbamd_pkg::OneMag) : req_i.operand_b;
    head           = '0;
    head.action    = req_i.action;
    head.operand_a = req_i.operand_a;
    head.operand_b = req_i.operand_b;
    head.mul_m     = {{W{1'b0}}, mag_a};
    head.mul_q     = mag_b;
    head.div_n     = mag_a;
    head.div_d     = mag_b;
  end

  assign chain_valid[0] = accept;
  assign chain_data[0]  = head;

  // The chain of cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    sbamd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  sbamd_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[N]),
    .data_i  (chain_data[N]),
    .done_o  (done_o),
    .res_o   (res_o)
  );

`ifndef SYNTHESIS
  // Every request comes out after the fixed latency of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##9 done_o)
    else $error("Result missing after the chain latency.");

  // No result appears without a request at the fixed latency before it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 9))
    else $error("Result without a matching request.");

  // A zero divisor gives zero value, remainder and overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.divide_by_zero) |->
      (res_o.result_value == '0 && res_o.remainder_value == '0 && !res_o.overflow_flag))
    else $error("Division by zero left a nonzero field.");
`endif

endmodule

[tb/sv/sbamd_result_monitor.sv]
// Result monitor of the signed byte ALU: predicts each result and compares it on arrival.
module sbamd_result_monitor
  import sbamd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_i,
  input  req_t            req_i,
  input  logic            done_i,
  input  res_t            res_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);

  localparam int MinVal = -(2 ** (DataWidth - 1));
  localparam int MaxVal = (2 ** (DataWidth - 1)) - 1;

  // Results still owed by the block, oldest first.
  res_t        owed_results[$];
  int unsigned mismatches = 0;

  // Works out the result of one request from the operands alone.
  function automatic res_t predict_result(req_t rq);
    res_t                        r;
    int                          a;
    int                          b;
    int                          exact;
    int                          mag_a;
    int                          mag_b;
    logic                        negate;
    logic signed [DataWidth-1:0] wrapped;
    r      = '0;
    a      = int'(rq.operand_a);
    b      = int'(rq.operand_b);
    mag_a  = (a < 0) ? -a : a;
    mag_b  = (b < 0) ? -b : b;
    negate = (a < 0) != (b < 0);
    case (rq.action) inside
      ActAdd, ActSub: begin
        exact = (rq.action == ActAdd) ? a + b : a - b;
        r.overflow_flag = (exact < MinVal) || (exact > MaxVal);
        wrapped = exact[DataWidth-1:0];
        r.result_value = wrapped;
      end
      ActMul: begin
        // The product of two byte magnitudes always fits the result field.
        exact = mag_a * mag_b;
        r.result_value = ProdWidth'(negate ? -exact : exact);
      end
      ActDiv: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          exact = negate ? -(mag_a / mag_b) : (mag_a / mag_b);
          // Only the most negative value over minus one leaves the byte range.
          r.overflow_flag = (exact < MinVal) || (exact > MaxVal);
          wrapped = exact[DataWidth-1:0];
          r.result_value = wrapped;
          // The remainder follows the sign of the dividend.
          r.remainder_value = DataWidth'((a < 0) ? -(mag_a % mag_b) : (mag_a % mag_b));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic compare_field(string field, logic [ProdWidth-1:0] want,
                               logic [ProdWidth-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Results are retired before new requests are recorded in the same cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      owed_results.delete();
    end else begin
      if (done_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, res_i);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          compare_field("result_value", want.result_value, res_i.result_value);
          compare_field("remainder_value", want.remainder_value, res_i.remainder_value);
          compare_field("overflow_flag", want.overflow_flag, res_i.overflow_flag);
          compare_field("divide_by_zero", want.divide_by_zero, res_i.divide_by_zero);
        end
      end
      if (start_i && !busy_i) begin
        owed_results.push_back(predict_result(req_i));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= owed_results.size();
  end

endmodule

[tb/sv/tb_signed_byte_alu_mul_div.sv]
// Testbench top of the signed byte ALU: request stimulus, reset, clock and verdict.
module tb_signed_byte_alu_mul_div;
  import sbamd_pkg::*;

  localparam int unsigned RandomRequests = 1050;
  // Requests in this window are sent back to back with no idle cycles.
  localparam int unsigned QuietFirst = 400;
  localparam int unsigned QuietLast = 700;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        done_o;
  res_t        res_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  signed_byte_alu_mul_div i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .res_o  (res_o)
  );

  sbamd_result_monitor i_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Sends one request, sometimes after a short idle gap, and waits until it is taken.
  task automatic issue_request(act_e act, int a, int b);
    if ((sent < QuietFirst || sent >= QuietLast) && $urandom_range(99) < 3) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= '{action: act, operand_a: a[DataWidth-1:0], operand_b: b[DataWidth-1:0]};
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  // Mostly uniform operands, with the byte extremes and the values around zero picked more often.
  function automatic int pick_operand();
    int corners[6] = '{-128, -127, -1, 0, 1, 127};
    if ($urandom_range(4) == 0) return corners[$urandom_range(5)];
    return int'($urandom_range(255)) - 128;
  endfunction

  initial begin
    act_e act;
    int   b;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Wrapping sums and differences, including subtraction of the most negative value.
    issue_request(ActAdd, 127, 1);
    issue_request(ActAdd, -128, -1);
    issue_request(ActAdd, -128, 127);
    issue_request(ActSub, 0, -128);
    issue_request(ActSub, -1, -128);
    issue_request(ActSub, -128, 1);
    issue_request(ActSub, 127, -128);
    issue_request(ActSub, -128, -128);
    // Products at the extremes of both signs.
    issue_request(ActMul, -128, -128);
    issue_request(ActMul, 127, -128);
    issue_request(ActMul, -128, 127);
    issue_request(ActMul, 127, 127);
    issue_request(ActMul, -1, -1);
    issue_request(ActMul, 0, -128);
    // Divisions: sign handling, the wrapping quotient and zero divisors.
    issue_request(ActDiv, -128, -1);
    issue_request(ActDiv, 100, 0);
    issue_request(ActDiv, -128, 0);
    issue_request(ActDiv, 127, -128);
    issue_request(ActDiv, -128, 127);
    issue_request(ActDiv, -7, 2);
    issue_request(ActDiv, 7, -2);
    issue_request(ActDiv, -128, -128);
    issue_request(ActDiv, -128, 1);
    issue_request(ActDiv, 0, 5);

    // Random requests; zero divisors are made more likely for divisions.
    repeat (RandomRequests) begin
      act = act_e'($urandom_range(3));
      b = pick_operand();
      if (act == ActDiv && $urandom_range(9) == 0) b = 0;
      issue_request(act, pick_operand(), b);
    end
    start <= 1'b0;

    // Drain the pipeline, then allow a few cycles for stray results.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/sbamd_pkg.sv
rtl/sbamd_cell.sv
rtl/sbamd_out.sv
rtl/signed_byte_alu_mul_div.sv
tb/sv/sbamd_result_monitor.sv
tb/sv/tb_signed_byte_alu_mul_div.sv
